[rtl/core/serial_frame_receiver_top_defines.svh]
// ----------------------------------------------------------------------------
// Serial frame receiver assertion macros
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_TOP_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SFR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("serial frame receiver assertion failed");
`define SFR_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("serial frame receiver sequence assertion failed");
`else
`define SFR_ASSERT(lbl, clk, rstn, prop)
`define SFR_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

[rtl/core/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// Serial frame receiver package
// Shared types, sync constants and the type size lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  localparam int unsigned LEN_W = 12;

  localparam logic [7:0] SYNC_FIRST  = 8'h4B;
  localparam logic [7:0] SYNC_SECOND = 8'h53;
  localparam logic [7:0] TRAILER_OK  = 8'h0D;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_END    = 2'd2
  } sfr_kind_e;

  typedef struct packed {
    sfr_kind_e        kind;
    logic [3:0]       frame_type;
    logic [7:0]       param_one;
    logic [7:0]       param_two;
    logic [LEN_W-1:0] payload_bytes;
    logic [LEN_W-1:0] element_count;
    logic [7:0]       data_byte;
    logic             end_status;
    logic             last;
  } sfr_result_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } sfr_word_t;

  // log2 of element size; sizes 0 and 1 give no division
  function automatic logic [1:0] size_shift(input logic [3:0] frame_type);
    logic [1:0] sh;
    case (frame_type)
      4'd1, 4'd5, 4'd9:  sh = 2'd1;
      4'd2, 4'd6, 4'd10: sh = 2'd2;
      4'd3, 4'd7, 4'd11: sh = 2'd3;
      default:           sh = 2'd0;
    endcase
    return sh;
  endfunction

endpackage

`default_nettype wire

[rtl/core/sfr_in_reg.sv]
// ----------------------------------------------------------------------------
// Serial frame receiver input register
// Captures one received word; holds it until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_in_reg
  import sfr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       advance_i,
  output logic            in_stall_o,
  output sfr_word_t       word_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       accept;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_byte_i;
    end
  end

  assign word_o.valid = valid_q;
  assign word_o.data  = byte_q;

endmodule

`default_nettype wire

[rtl/core/sfr_parser.sv]
// ----------------------------------------------------------------------------
// Serial frame receiver parser
// Sync hunt, header collection, checksum check and payload/trailer tracking.
// ----------------------------------------------------------------------------
`default_nettype none
`include "serial_frame_receiver_top_defines.svh"

module sfr_parser
  import sfr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  output logic            res_valid_o,
  output sfr_result_t     res_o
);

  localparam logic [2:0] PH_HUNT_K  = 3'd0;
  localparam logic [2:0] PH_HUNT_S  = 3'd1;
  localparam logic [2:0] PH_HEADER  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_TRAILER = 3'd4;

  localparam logic [2:0] POS_TL = 3'd0;
  localparam logic [2:0] POS_LN = 3'd1;
  localparam logic [2:0] POS_P1 = 3'd2;
  localparam logic [2:0] POS_P2 = 3'd3;

  logic [2:0]       phase_q, phase_d;
  logic [2:0]       pos_q, pos_d;
  logic [3:0]       type_q, type_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [7:0]       p1_q, p1_d;
  logic [7:0]       p2_q, p2_d;
  logic [7:0]       sum_q, sum_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic [LEN_W-1:0] rem_dec;

  assign rem_dec = rem_q - LEN_W'(1);

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    type_d      = type_q;
    len_d       = len_q;
    p1_d        = p1_q;
    p2_d        = p2_q;
    sum_d       = sum_q;
    rem_d       = rem_q;
    res_valid_o = 1'b0;

    res_o.kind          = KIND_HEADER;
    res_o.frame_type    = type_q;
    res_o.param_one     = p1_q;
    res_o.param_two     = p2_q;
    res_o.payload_bytes = len_q;
    res_o.element_count = len_q >> size_shift(type_q);
    res_o.data_byte     = 8'h00;
    res_o.end_status    = 1'b0;
    res_o.last          = 1'b0;

    if (step_i) begin
      unique case (phase_q)
        PH_HUNT_S: begin
          if (byte_i == SYNC_SECOND) begin
            phase_d = PH_HEADER;
            pos_d   = POS_TL;
            sum_d   = 8'h00;
          end else if (byte_i != SYNC_FIRST) begin
            phase_d = PH_HUNT_K;
          end
        end
        PH_HEADER: begin
          if (pos_q == POS_TL || pos_q == POS_LN || pos_q == POS_P1 || pos_q == POS_P2) begin
            sum_d = sum_q + byte_i;
            pos_d = pos_q + 3'd1;
            unique case (pos_q)
              POS_TL: begin
                type_d = byte_i[7:4];
                len_d  = {byte_i[3:0], 8'h00};
              end
              POS_LN:  len_d = {len_q[LEN_W-1:8], byte_i};
              POS_P1:  p1_d  = byte_i;
              default: p2_d  = byte_i;
            endcase
          end else begin
            pos_d = POS_TL;
            if (byte_i != sum_q) begin
              phase_d = PH_HUNT_K;
            end else begin
              rem_d       = len_q;
              phase_d     = (len_q == '0) ? PH_TRAILER : PH_PAYLOAD;
              res_valid_o = 1'b1;
            end
          end
        end
        PH_PAYLOAD: begin
          rem_d = rem_dec;
          if (rem_dec == '0) begin
            phase_d = PH_TRAILER;
          end
          res_valid_o     = 1'b1;
          res_o.kind      = KIND_DATA;
          res_o.data_byte = byte_i;
        end
        PH_TRAILER: begin
          phase_d          = PH_HUNT_K;
          res_valid_o      = 1'b1;
          res_o.kind       = KIND_END;
          res_o.end_status = (byte_i != TRAILER_OK);
          res_o.last       = 1'b1;
        end
        default: begin
          phase_d = (byte_i == SYNC_FIRST) ? PH_HUNT_S : PH_HUNT_K;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT_K;
      pos_q   <= POS_TL;
      type_q  <= 4'h0;
      len_q   <= '0;
      p1_q    <= 8'h00;
      p2_q    <= 8'h00;
      sum_q   <= 8'h00;
      rem_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      type_q  <= type_d;
      len_q   <= len_d;
      p1_q    <= p1_d;
      p2_q    <= p2_d;
      sum_q   <= sum_d;
      rem_q   <= rem_d;
    end
  end

  // checksum mismatch drops the frame silently
  `SFR_ASSERT(a_bad_sum_no_result, clk_i, rst_ni, (step_i && phase_q == PH_HEADER && pos_q > POS_P2 && byte_i != sum_q) |-> !res_valid_o)
  `SFR_ASSERT_NEXT(a_last_payload_to_trailer, clk_i, rst_ni, step_i && phase_q == PH_PAYLOAD && rem_q == LEN_W'(1), phase_q == PH_TRAILER)
  `SFR_ASSERT_NEXT(a_trailer_to_hunt, clk_i, rst_ni, step_i && phase_q == PH_TRAILER, phase_q == PH_HUNT_K && pos_q == POS_TL)
  `SFR_ASSERT(a_payload_count_live, clk_i, rst_ni, (phase_q == PH_PAYLOAD) |-> (rem_q != '0))

endmodule

`default_nettype wire

[rtl/core/sfr_out_reg.sv]
// ----------------------------------------------------------------------------
// Serial frame receiver result register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_out_reg
  import sfr_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         load_i,
  input  wire logic         res_valid_i,
  input  wire sfr_result_t  res_i,
  input  wire logic         out_stall_i,
  output logic              free_o,
  output logic              out_valid_o,
  output sfr_result_t       res_o
);

  logic        valid_q, valid_d;
  sfr_result_t res_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = res_valid_i;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

[rtl/core/serial_frame_receiver_top.sv]
// ----------------------------------------------------------------------------
// Serial frame receiver top level
// Deframes 'K','S' sync-header frames from a stream of received bytes.
// ----------------------------------------------------------------------------
// Input channel: one received byte per word on in_byte_i, in_valid_i/in_stall_o.
// Output channel: one result word per header, payload byte or frame end on
//   kind_o and the field ports, out_valid_o/out_stall_i.
// Datapath: each accepted byte is held in the input register, stepped through
//   the parser and registered in the result register, from which it is taken
//   while out_stall_i is low.
// Throughput: one byte per cycle while out_stall_i does not hold a full result
//   register, set by the combinational parser step between the two registers.
// Sync, header and bad-checksum bytes produce no result word.
// Reset: both registers empty, parser hunting for 'K', held header zero.
// When out_stall_i holds a full result register, the parser halts and the
//   input register holds its byte; in_stall_o rises once that byte waits.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_receiver_top
  import sfr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [7:0]       in_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [1:0]            kind_o,
  output logic [3:0]            frame_type_o,
  output logic [7:0]            param_one_o,
  output logic [7:0]            param_two_o,
  output logic [LEN_W-1:0]      payload_bytes_o,
  output logic [LEN_W-1:0]      element_count_o,
  output logic [7:0]            data_byte_o,
  output logic                  end_status_o,
  output logic                  last_o
);

  sfr_word_t   word;
  logic        out_free;
  logic        advance;
  logic        res_valid;
  sfr_result_t res;
  sfr_result_t res_out;

  assign advance = word.valid && out_free;

  sfr_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .advance_i  (advance),
    .in_stall_o (in_stall_o),
    .word_o     (word)
  );

  sfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (word.data),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sfr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .res_o       (res_out)
  );

  assign kind_o          = res_out.kind;
  assign frame_type_o    = res_out.frame_type;
  assign param_one_o     = res_out.param_one;
  assign param_two_o     = res_out.param_two;
  assign payload_bytes_o = res_out.payload_bytes;
  assign element_count_o = res_out.element_count;
  assign data_byte_o     = res_out.data_byte;
  assign end_status_o    = res_out.end_status;
  assign last_o          = res_out.last;

endmodule

`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// Serial frame receiver testbench
// Feeds byte streams of sync-header frames, broken syncs, bad checksums and
// noise. It predicts header, payload and frame-end words from the accepted
// bytes (directed rows give theirs in a table), checks each output word field
// by field, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import sfr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT_K,
    PH_HUNT_S,
    PH_HEADER,
    PH_PAYLOAD,
    PH_TRAILER
  } parse_phase_e;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        typed;
    sfr_result_t res;
  } stim_row_t;

  localparam int unsigned ELEM_SIZE [16] = '{1, 2, 4, 8, 1, 2, 4, 8, 0, 2, 4, 8, 0, 0, 0, 0};
  localparam int unsigned RAND_ITEMS = 1650;
  localparam int unsigned HOLD_CYCLES = 300;

  localparam sfr_result_t NO_RES = '0;
  localparam sfr_result_t A_HDR = '{KIND_HEADER, 4'hF, 8'hFF, 8'h00, 12'd0, 12'd0, 8'h00, 1'b0,
                                    1'b0};
  localparam sfr_result_t A_END = '{KIND_END, 4'hF, 8'hFF, 8'h00, 12'd0, 12'd0, 8'h00, 1'b1,
                                    1'b1};
  localparam sfr_result_t C_HDR = '{KIND_HEADER, 4'h3, 8'h00, 8'hFF, 12'd2, 12'd0, 8'h00, 1'b0,
                                    1'b0};
  localparam sfr_result_t C_END = '{KIND_END, 4'h3, 8'h00, 8'hFF, 12'd2, 12'd0, 8'h00, 1'b0,
                                    1'b1};

  // repeated K, zero length, max params, bad trailer; sync bytes as payload;
  // broken sync then all-ones header with a K as checksum
  localparam stim_row_t DIR_ROWS [28] = '{
    '{SYNC_FIRST, 1'b0, NO_RES}, '{SYNC_FIRST, 1'b0, NO_RES}, '{SYNC_SECOND, 1'b0, NO_RES},
    '{8'hF0, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'hEF, 1'b1, A_HDR}, '{8'h00, 1'b1, A_END},
    '{SYNC_FIRST, 1'b0, NO_RES}, '{SYNC_SECOND, 1'b0, NO_RES},
    '{8'h30, 1'b0, NO_RES}, '{8'h02, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES}, '{8'h31, 1'b1, C_HDR},
    '{SYNC_FIRST, 1'b0, NO_RES}, '{SYNC_SECOND, 1'b0, NO_RES}, '{TRAILER_OK, 1'b1, C_END},
    '{SYNC_FIRST, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{SYNC_FIRST, 1'b0, NO_RES}, '{SYNC_SECOND, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES}, '{SYNC_FIRST, 1'b0, NO_RES}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [7:0]       in_byte_i = 8'h00;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [1:0]       kind_o;
  logic [3:0]       frame_type_o;
  logic [7:0]       param_one_o;
  logic [7:0]       param_two_o;
  logic [LEN_W-1:0] payload_bytes_o;
  logic [LEN_W-1:0] element_count_o;
  logic [7:0]       data_byte_o;
  logic             end_status_o;
  logic             last_o;

  // deframer state as predicted
  parse_phase_e     rx_phase = PH_HUNT_K;
  logic [2:0]       hdr_pos = '0;
  logic [3:0]       cur_type = '0;
  logic [LEN_W-1:0] cur_len = '0;
  logic [7:0]       cur_p1 = '0;
  logic [7:0]       cur_p2 = '0;
  logic [7:0]       hdr_sum = '0;
  logic [LEN_W-1:0] left_bytes = '0;

  sfr_result_t      pending_results[$];
  int unsigned      mismatches = 0;
  int unsigned      items_fed = 0;
  int unsigned      burst_left = 0;
  bit               hold_request = 1'b0;

  serial_frame_receiver_top dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [LEN_W-1:0] elements_for(logic [3:0] t, logic [LEN_W-1:0] n);
    int unsigned sz;
    sz = ELEM_SIZE[t];
    if (sz > 1) return LEN_W'(n / sz);
    return n;
  endfunction

  function automatic sfr_result_t frame_word(sfr_kind_e k, logic [7:0] d, logic st,
                                             logic lst);
    sfr_result_t r;
    r.kind          = k;
    r.frame_type    = cur_type;
    r.param_one     = cur_p1;
    r.param_two     = cur_p2;
    r.payload_bytes = cur_len;
    r.element_count = elements_for(cur_type, cur_len);
    r.data_byte     = d;
    r.end_status    = st;
    r.last          = lst;
    return r;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output sfr_result_t r);
    r = NO_RES;
    case (rx_phase)
      PH_HUNT_S: begin
        if (b == SYNC_SECOND) begin
          rx_phase = PH_HEADER;
          hdr_pos  = '0;
          hdr_sum  = '0;
        end else if (b != SYNC_FIRST) begin
          rx_phase = PH_HUNT_K;
        end
        return 1'b0;
      end
      PH_HEADER: begin
        case (hdr_pos)
          3'd0: begin
            cur_type = b[7:4];
            cur_len  = {b[3:0], 8'h00};
          end
          3'd1: cur_len[7:0] = b;
          3'd2: cur_p1 = b;
          3'd3: cur_p2 = b;
          default: begin
            hdr_pos = '0;
            if (b != hdr_sum) begin
              rx_phase = PH_HUNT_K;
              return 1'b0;
            end
            left_bytes = cur_len;
            rx_phase   = (cur_len == '0) ? PH_TRAILER : PH_PAYLOAD;
            r = frame_word(KIND_HEADER, 8'h00, 1'b0, 1'b0);
            return 1'b1;
          end
        endcase
        hdr_sum = hdr_sum + b;
        hdr_pos = hdr_pos + 3'd1;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        left_bytes = left_bytes - 1'b1;
        if (left_bytes == '0) rx_phase = PH_TRAILER;
        r = frame_word(KIND_DATA, b, 1'b0, 1'b0);
        return 1'b1;
      end
      PH_TRAILER: begin
        rx_phase = PH_HUNT_K;
        r = frame_word(KIND_END, 8'h00, b != TRAILER_OK, 1'b1);
        return 1'b1;
      end
      default: begin
        rx_phase = (b == SYNC_FIRST) ? PH_HUNT_S : PH_HUNT_K;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return SYNC_FIRST;
      1: return SYNC_SECOND;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return LEN_W'($urandom_range(0, 4));
    if (sel < 85) return LEN_W'($urandom_range(5, 32));
    return LEN_W'($urandom_range(33, 300));
  endfunction

  // offer one word; valid stays up across a burst
  task automatic put_byte(input logic [7:0] b, input bit typed = 1'b0,
                          input sfr_result_t typed_res = NO_RES);
    sfr_result_t r;
    bit          got;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    items_fed++;
    got = deframe_byte(b, r);
    if (typed) pending_results.push_back(typed_res);
    else if (got) pending_results.push_back(r);
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_frame(input logic [LEN_W-1:0] len, input bit good_sum,
                            input bit good_trailer);
    logic [7:0] tl, ln, p1, p2, ck, tr;
    tl = {4'($urandom_range(0, 15)), len[11:8]};
    ln = len[7:0];
    p1 = 8'($urandom);
    p2 = 8'($urandom);
    ck = tl + ln + p1 + p2;
    if (!good_sum) ck = ck ^ 8'($urandom_range(1, 255));
    put_byte(SYNC_FIRST);
    put_byte(SYNC_SECOND);
    put_byte(tl);
    put_byte(ln);
    put_byte(p1);
    put_byte(p2);
    put_byte(ck);
    if (good_sum) begin
      repeat (len) put_byte(rand_byte());
      tr = good_trailer ? TRAILER_OK : 8'($urandom);
      put_byte(tr);
    end
  endtask

  // stimulus
  initial begin
    int unsigned rand_start, sel;
    bit          held, drained;
    logic [7:0]  b;
    held    = 1'b0;
    drained = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR_ROWS[i]) put_byte(DIR_ROWS[i].rx_byte, DIR_ROWS[i].typed, DIR_ROWS[i].res);
    wait_drain();

    // full-length header with a broken checksum
    send_frame(12'hFFF, 1'b0, 1'b1);
    rand_start = items_fed;
    while (items_fed - rand_start < RAND_ITEMS) begin
      if (!held && items_fed - rand_start > 300) begin
        hold_request = 1'b1;
        held = 1'b1;
      end
      if (!drained && items_fed - rand_start > 1000) begin
        wait_drain();
        drained = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        send_frame(pick_len(), 1'b1, $urandom_range(0, 99) < 85);
      end else if (sel < 75) begin
        send_frame(LEN_W'($urandom), 1'b0, 1'b1);
      end else if (sel < 85) begin
        put_byte(SYNC_FIRST);
        repeat ($urandom_range(0, 2)) put_byte(SYNC_FIRST);
        b = 8'($urandom);
        if (b == SYNC_SECOND) b = 8'h00;
        put_byte(b);
      end else if (sel < 92) begin
        repeat ($urandom_range(1, 8)) put_byte(rand_byte());
      end else begin
        send_frame(pick_len(), 1'b1, 1'b0);
      end
    end

    wait_drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // output stall pattern, plus one long hold on request
  initial begin
    int unsigned span_left, stall_pct, hold_left;
    span_left = 0;
    stall_pct = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (span_left == 0) begin
        span_left = $urandom_range(5, 60);
        stall_pct = 25 * $urandom_range(0, 3);
      end
      span_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    sfr_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: kind %0d data %02h last %0d", kind_o, data_byte_o, last_o);
      end else begin
        e = pending_results.pop_front();
        if (kind_o !== e.kind || frame_type_o !== e.frame_type ||
            param_one_o !== e.param_one || param_two_o !== e.param_two ||
            payload_bytes_o !== e.payload_bytes || element_count_o !== e.element_count ||
            data_byte_o !== e.data_byte || end_status_o !== e.end_status ||
            last_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp: kind %0d type %0h p1 %02h p2 %02h len %0d elem %0d",
                     e.kind, e.frame_type, e.param_one, e.param_two, e.payload_bytes,
                     e.element_count);
            $display("              data %02h status %0d last %0d",
                     e.data_byte, e.end_status, e.last);
            $display("         got: kind %0d type %0h p1 %02h p2 %02h len %0d elem %0d",
                     kind_o, frame_type_o, param_one_o, param_two_o, payload_bytes_o,
                     element_count_o);
            $display("              data %02h status %0d last %0d",
                     data_byte_o, end_status_o, last_o);
          end
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
